/* rtl/gregorian_date_add_days_assert.svh */
// Assertion macros shared by the date adder modules.
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define GDATE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define GDATE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/gdate_pkg.sv */
// Types, constants and month table for the Gregorian date adder.
package gdate_pkg;

	localparam int DAY_W  = 17;
	localparam int YEAR_W = 13;
	localparam int MOD_W  = 12;
	localparam int PC_W   = 3;

	localparam logic [11:0] YEAR_MAX = 12'd4095;
	localparam logic [MOD_W-1:0] CYCLE_LEN  = MOD_W'(400);
	localparam logic [MOD_W-1:0] CYCLE_LAST = MOD_W'(399);
	localparam logic [MOD_W-1:0] CENT_1 = MOD_W'(100);
	localparam logic [MOD_W-1:0] CENT_2 = MOD_W'(200);
	localparam logic [MOD_W-1:0] CENT_3 = MOD_W'(300);

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [1:0] OP_IDLE   = 2'd0;
	localparam logic [1:0] OP_MODSUB = 2'd1;
	localparam logic [1:0] OP_WALK   = 2'd2;
	localparam logic [1:0] OP_DONE   = 2'd3;

	localparam logic [1:0] COND_NEVER     = 2'd0;
	localparam logic [1:0] COND_IDLE_WAIT = 2'd1;
	localparam logic [1:0] COND_DAY_GT    = 2'd2;
	localparam logic [1:0] COND_ALWAYS    = 2'd3;

	localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
	localparam logic [PC_W-1:0] PC_MOD3  = 3'd1;
	localparam logic [PC_W-1:0] PC_MOD2  = 3'd2;
	localparam logic [PC_W-1:0] PC_MOD1  = 3'd3;
	localparam logic [PC_W-1:0] PC_MOD0  = 3'd4;
	localparam logic [PC_W-1:0] PC_WALK  = 3'd5;
	localparam logic [PC_W-1:0] PC_DONE  = 3'd6;

	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [11:0] start_year;
		logic [15:0] add_days;
	} gdate_req_t;

	typedef struct packed {
		logic [4:0]  result_day;
		logic [3:0]  result_month;
		logic [11:0] result_year;
		logic        year_overflow;
	} gdate_res_t;

	typedef struct packed {
		logic [1:0]      op;
		logic [1:0]      shamt;
		logic [1:0]      cond;
		logic [PC_W-1:0] target;
	} gdate_ctl_t;

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

/* rtl/gdate_urom.sv */
// Microcode store: one control word per program step.
module gdate_urom (
	input  logic [gdate_pkg::PC_W-1:0] pc,
	output gdate_pkg::gdate_ctl_t      ctl
);

	always_comb begin
		case (pc)
			gdate_pkg::PC_IDLE: ctl = '{gdate_pkg::OP_IDLE, 2'd0,
				gdate_pkg::COND_IDLE_WAIT, gdate_pkg::PC_IDLE};
			gdate_pkg::PC_MOD3: ctl = '{gdate_pkg::OP_MODSUB, 2'd3,
				gdate_pkg::COND_NEVER, gdate_pkg::PC_IDLE};
			gdate_pkg::PC_MOD2: ctl = '{gdate_pkg::OP_MODSUB, 2'd2,
				gdate_pkg::COND_NEVER, gdate_pkg::PC_IDLE};
			gdate_pkg::PC_MOD1: ctl = '{gdate_pkg::OP_MODSUB, 2'd1,
				gdate_pkg::COND_NEVER, gdate_pkg::PC_IDLE};
			gdate_pkg::PC_MOD0: ctl = '{gdate_pkg::OP_MODSUB, 2'd0,
				gdate_pkg::COND_NEVER, gdate_pkg::PC_IDLE};
			// loop here while the day still exceeds the month length
			gdate_pkg::PC_WALK: ctl = '{gdate_pkg::OP_WALK, 2'd0,
				gdate_pkg::COND_DAY_GT, gdate_pkg::PC_WALK};
			gdate_pkg::PC_DONE: ctl = '{gdate_pkg::OP_DONE, 2'd0,
				gdate_pkg::COND_ALWAYS, gdate_pkg::PC_IDLE};
			default: ctl = '{gdate_pkg::OP_IDLE, 2'd0,
				gdate_pkg::COND_ALWAYS, gdate_pkg::PC_IDLE};
		endcase
	end

endmodule

/* rtl/gdate_seq.sv */
// Step counter with conditional jumps over the microcode store.
module gdate_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   day_gt,
	output logic                   busy,
	output logic                   load,
	output gdate_pkg::gdate_ctl_t  ctl
);

	logic [gdate_pkg::PC_W-1:0] pc_q;
	logic                       take;

	gdate_urom u_urom (
		.pc  (pc_q),
		.ctl (ctl)
	);

	always_comb begin
		case (ctl.cond)
			gdate_pkg::COND_NEVER:     take = 1'b0;
			gdate_pkg::COND_IDLE_WAIT: take = !start;
			gdate_pkg::COND_DAY_GT:    take = day_gt;
			gdate_pkg::COND_ALWAYS:    take = 1'b1;
			default:                   take = 1'b1;
		endcase
	end

	assign busy = (pc_q != gdate_pkg::PC_IDLE);
	assign load = !busy && start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= gdate_pkg::PC_IDLE;
		end else if (take) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

/* rtl/gdate_dpath.sv */
// Date datapath: day, month, year and year-within-400 registers.
module gdate_dpath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  gdate_pkg::gdate_req_t  request,
	input  gdate_pkg::gdate_ctl_t  ctl,
	output logic                   day_gt,
	output logic                   done,
	output gdate_pkg::gdate_res_t  result
);

`include "gregorian_date_add_days_assert.svh"

	logic [gdate_pkg::DAY_W-1:0]  day_q;
	logic [3:0]                   month_q;
	logic [gdate_pkg::YEAR_W-1:0] year_q;
	logic [gdate_pkg::MOD_W-1:0]  m400_q;
	gdate_pkg::gdate_res_t        result_q;
	logic                         done_q;

	logic                         leap;
	logic [4:0]                   len;
	logic [gdate_pkg::MOD_W-1:0]  sub;
	logic [3:0]                   month_in;

	// year % 4 from the low bits, century years from the 400-year position
	assign leap = (year_q[1:0] == 2'd0) && (m400_q != gdate_pkg::CENT_1) &&
		(m400_q != gdate_pkg::CENT_2) && (m400_q != gdate_pkg::CENT_3);
	assign len    = gdate_pkg::month_len(month_q, leap);
	assign day_gt = day_q > gdate_pkg::DAY_W'(len);
	assign sub    = gdate_pkg::CYCLE_LEN << ctl.shamt;

	always_comb begin
		if (request.start_month == 4'd0) begin
			month_in = gdate_pkg::MONTH_JAN;
		end else if (request.start_month > gdate_pkg::MONTH_DEC) begin
			month_in = gdate_pkg::MONTH_DEC;
		end else begin
			month_in = request.start_month;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			day_q   <= gdate_pkg::DAY_W'(request.start_day) + gdate_pkg::DAY_W'(request.add_days);
			month_q <= month_in;
			year_q  <= gdate_pkg::YEAR_W'(request.start_year);
			m400_q  <= request.start_year;
		end else begin
			case (ctl.op)
				gdate_pkg::OP_MODSUB: begin
					if (m400_q >= sub) begin
						m400_q <= m400_q - sub;
					end
				end
				gdate_pkg::OP_WALK: begin
					if (day_gt) begin
						day_q <= day_q - gdate_pkg::DAY_W'(len);
						if (month_q == gdate_pkg::MONTH_DEC) begin
							month_q <= gdate_pkg::MONTH_JAN;
							year_q  <= year_q + 1'b1;
							m400_q  <= (m400_q == gdate_pkg::CYCLE_LAST) ? '0 : m400_q + 1'b1;
						end else begin
							month_q <= month_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == gdate_pkg::OP_DONE) begin
			result_q.result_day    <= day_q[4:0];
			result_q.result_month  <= month_q;
			result_q.result_year   <= year_q[gdate_pkg::YEAR_W-1] ? gdate_pkg::YEAR_MAX
				: year_q[11:0];
			result_q.year_overflow <= year_q[gdate_pkg::YEAR_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctl.op == gdate_pkg::OP_DONE);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`GDATE_ASSERT_SAME(a_walk_mod_range, ctl.op == gdate_pkg::OP_WALK, m400_q < gdate_pkg::CYCLE_LEN, "year position out of range during walk")
	`GDATE_ASSERT_SAME(a_walk_month_range, ctl.op == gdate_pkg::OP_WALK, (month_q >= gdate_pkg::MONTH_JAN) && (month_q <= gdate_pkg::MONTH_DEC), "month out of range during walk")

endmodule

/* rtl/gregorian_date_add_days.sv */
// One request at a time: the start year is reduced modulo 400, then the month
// walk, one month per cycle, runs until the day fits the month and sets the rate.
// A new request is taken in the same cycle that done pulses for the previous one.
// Reset (arst_n low) returns the sequencer to idle and clears done; busy drops at once.
// The receiver cannot stall: done is high for a single cycle; result holds until the next done.
module gregorian_date_add_days (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  gdate_pkg::gdate_req_t request,
	output logic                  done,
	output gdate_pkg::gdate_res_t result
);

`include "gregorian_date_add_days_assert.svh"

	gdate_pkg::gdate_ctl_t ctl;
	logic                  load;
	logic                  day_gt;

	// Sequencer: the program reduces the start year modulo 400 in four
	// compare-and-subtract steps, walks months while the day exceeds the
	// month length, then registers the result.
	gdate_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.day_gt (day_gt),
		.busy   (busy),
		.load   (load),
		.ctl    (ctl)
	);

	// Datapath: hold the running date, advance one month per walk step.
	gdate_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.request (request),
		.ctl     (ctl),
		.day_gt  (day_gt),
		.done    (done),
		.result  (result)
	);

	`GDATE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after request")
	`GDATE_ASSERT_SAME(a_done_idle, done, !busy, "done while still busy")
	`GDATE_ASSERT_SAME(a_ovf_sat, done && result.year_overflow, result.result_year == gdate_pkg::YEAR_MAX, "overflow without saturated year")

endmodule
